FILE: rtl/core/assert_macros.svh
// assertion macros used by the core datapath
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// condition checked on every rising clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`endif

FILE: rtl/core/miie_pkg.sv
// package for the mips integer executor: codes, types, helper functions
// no dependencies
package miie_pkg;
    localparam int MemWords = 16384;
    localparam int MemAw = $clog2(MemWords);

    localparam logic [1:0] OP_EXEC = 2'd0;
    localparam logic [1:0] OP_LOAD = 2'd1;
    localparam logic [1:0] OP_WREG = 2'd2;
    localparam logic [1:0] OP_RREG = 2'd3;

    localparam logic [2:0] ST_OK = 3'd0;
    localparam logic [2:0] ST_SYSCALL = 3'd1;
    localparam logic [2:0] ST_INVALID = 3'd2;
    localparam logic [2:0] ST_RANGE = 3'd3;
    localparam logic [2:0] ST_HALT = 3'd4;

    localparam logic [1:0] CFG_START_PC = 2'd0;
    localparam logic [1:0] CFG_MEM_BASE = 2'd1;
    localparam logic [1:0] CFG_TEXT_END = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE, S_READ, S_EXEC, S_MUL, S_DIV, S_WB, S_OUT
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic capture;
        logic read;
        logic exec;
        logic mul_start;
        logic div_start;
        logic div_step;
        logic wb;
        logic out_load;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic is_mul;
        logic is_div;
        logic div_last;
    } sts_t;

    function automatic logic [31:0] lane_bits(input logic [3:0] m);
        logic [31:0] r;
        r = {{8{m[3]}}, {8{m[2]}}, {8{m[1]}}, {8{m[0]}}};
        return r;
    endfunction
endpackage

FILE: rtl/core/mips_integer_instruction_executor_unit.sv
// top level of the mips-i integer executor
// depends on miie_pkg, miie_ctrl, miie_dpath
//
// channel   | direction | contents
// s_axis    | in        | tdata: op, instr, target_addr, write_data
// m_axis    | out       | tdata: next_pc .. lo_value
// cfg       | in        | start_pc, mem_base, text_end
//
// after accept an item passes the read, execute, writeback and output steps;
//   the output step loads the result and returns the block to idle
// mult/multu add a multiply step for the registered multiplier
// div/divu add a divide step that runs the one-bit-per-cycle divider to its end
// one item at a time; a waiting result is held in the output register and the
//   next result stays in the output step until it is taken
// reset clears registers and hi/lo and sets pc to its reset address; data memory
//   is undefined until written
module mips_integer_instruction_executor_unit (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // op[1:0], instr[33:2], target_addr[65:34], write_data[97:66], zero pad
    input  logic [103:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // next_pc[31:0], status[34:32], reg_written[35], reg_index[40:36],
    // reg_value[72:41], mem_written[73], mem_addr[105:74], mem_value[137:106],
    // mem_byte_mask[141:138], hi_value[173:142], lo_value[205:174], zero pad
    output logic [207:0] m_axis_tdata,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_data
);
    import miie_pkg::*;

    cmd_t cmd;
    sts_t sts;
    logic idle, in_fire, ovalid_reg;

    logic [31:0] next_pc, reg_value, mem_addr, mem_value, hi_value, lo_value;
    logic [2:0]  status;
    logic        reg_written, mem_written;
    logic [4:0]  reg_index;
    logic [3:0]  mem_byte_mask;

    // accept when idle; output register parts the two sides
    assign s_axis_tready = idle;
    assign in_fire = s_axis_tvalid && s_axis_tready;

    miie_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_fire(in_fire),
        .out_busy(ovalid_reg && !m_axis_tready),
        .sts(sts), .cmd(cmd), .idle(idle)
    );

    miie_dpath u_dpath (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .op(s_axis_tdata[1:0]), .instr(s_axis_tdata[33:2]),
        .target_addr(s_axis_tdata[65:34]), .write_data(s_axis_tdata[97:66]),
        .next_pc(next_pc), .status(status), .reg_written(reg_written),
        .reg_index(reg_index), .reg_value(reg_value), .mem_written(mem_written),
        .mem_addr(mem_addr), .mem_value(mem_value), .mem_byte_mask(mem_byte_mask),
        .hi_value(hi_value), .lo_value(lo_value)
    );

    // output valid: set on load, cleared when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ovalid_reg <= 1'b0;
        else if (cmd.out_load)
            ovalid_reg <= 1'b1;
        else if (m_axis_tready)
            ovalid_reg <= 1'b0;
    end

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata = {2'd0, lo_value, hi_value, mem_byte_mask, mem_value, mem_addr,
                           mem_written, reg_value, reg_index, reg_written, status, next_pc};
endmodule

FILE: rtl/core/miie_ctrl.sv
// controller state machine of the mips integer executor
// depends on miie_pkg
module miie_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_fire,
    input  logic              out_busy,
    input  miie_pkg::sts_t    sts,
    output miie_pkg::cmd_t    cmd,
    output logic              idle
);
    import miie_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (in_fire) state_next = S_READ;
            S_READ: state_next = S_EXEC;
            S_EXEC:
            begin
                if (sts.is_mul) state_next = S_MUL;
                else if (sts.is_div) state_next = S_DIV;
                else state_next = S_WB;
            end
            S_MUL: state_next = S_WB;
            S_DIV: if (sts.div_last) state_next = S_WB;
            S_WB: state_next = S_OUT;
            S_OUT: if (!out_busy) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        idle = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                idle = 1'b1;
                cmd.capture = in_fire;
            end
            S_READ: cmd.read = 1'b1;
            S_EXEC:
            begin
                cmd.exec = 1'b1;
                cmd.mul_start = sts.is_mul;
                cmd.div_start = sts.is_div;
            end
            S_MUL: ;
            S_DIV: cmd.div_step = 1'b1;
            S_WB: cmd.wb = 1'b1;
            S_OUT: cmd.out_load = !out_busy;
            default: ;
        endcase
    end
endmodule

FILE: rtl/core/miie_dpath.sv
// datapath of the mips integer executor: register file, hi/lo, pc, memory, alu
// depends on miie_pkg and assert_macros.svh
module miie_dpath (
    input  logic            clk,
    input  logic            rst_n,
    input  miie_pkg::cmd_t  cmd,
    output miie_pkg::sts_t  sts,
    input  logic            cfg_we,
    input  logic [1:0]      cfg_index,
    input  logic [31:0]     cfg_data,
    input  logic [1:0]      op,
    input  logic [31:0]     instr,
    input  logic [31:0]     target_addr,
    input  logic [31:0]     write_data,
    output logic [31:0]     next_pc,
    output logic [2:0]      status,
    output logic            reg_written,
    output logic [4:0]      reg_index,
    output logic [31:0]     reg_value,
    output logic            mem_written,
    output logic [31:0]     mem_addr,
    output logic [31:0]     mem_value,
    output logic [3:0]      mem_byte_mask,
    output logic [31:0]     hi_value,
    output logic [31:0]     lo_value
);
    import miie_pkg::*;
`include "assert_macros.svh"

    logic [31:0] mem_base_reg, text_end_reg;
    logic [31:0] gpr_reg [32];
    logic [31:0] hi_reg, lo_reg, pc_reg;
    logic [31:0] mem [MemWords];

    logic [1:0]  op_reg;
    logic [31:0] ins_reg, ta_reg, wd_reg;
    logic [31:0] a_reg, b_reg, w_reg;
    logic [MemAw-1:0] wi_reg;
    logic        inrange_reg;

    // result registers set in the execute step
    logic [31:0] npc_reg, val_reg, ma_reg, mv_reg, nhi_reg, nlo_reg;
    logic [2:0]  st_reg;
    logic        wr_reg, mw_reg;
    logic [4:0]  dst_reg, ri_reg;
    logic [3:0]  mm_reg;

    // multiply / divide
    logic [63:0] prod_reg;
    logic        mul_pend_reg;
    logic [31:0] dq_reg, dr_reg, dd_reg;
    logic [5:0]  dcnt_reg;
    logic        dneg_q_reg, dneg_r_reg, dvalid_reg, div_pend_reg;

    // decoded fields
    logic [5:0]  opc, fn;
    logic [4:0]  rs, rt, rd, sa;
    logic [31:0] imm, simm, ea, pc4, br_tgt;
    assign opc = ins_reg[31:26];
    assign fn = ins_reg[5:0];
    assign rs = ins_reg[25:21];
    assign rt = ins_reg[20:16];
    assign rd = ins_reg[15:11];
    assign sa = ins_reg[10:6];
    assign imm = {16'd0, ins_reg[15:0]};
    assign simm = {{16{ins_reg[15]}}, ins_reg[15:0]};
    assign pc4 = pc_reg + 32'd4;
    assign br_tgt = pc4 + {simm[29:0], 2'b00};

    // effective address before operands are read: computed in read step
    logic [31:0] off_exec, off_pre, rd_addr;
    logic [31:0] gpr_a, gpr_b;
    assign gpr_a = (rs == 5'd0) ? 32'd0 : gpr_reg[rs];
    assign gpr_b = (rt == 5'd0) ? 32'd0 : gpr_reg[rt];
    assign ea = a_reg + simm;
    assign rd_addr = (op_reg == OP_EXEC) ? gpr_a + simm : ta_reg;
    assign off_exec = rd_addr - mem_base_reg;
    assign off_pre = off_exec;

    assign sts.is_mul = (op_reg == OP_EXEC) && (pc_reg < text_end_reg) && (opc == 6'd0)
                        && (fn == 6'd24 || fn == 6'd25);
    assign sts.is_div = (op_reg == OP_EXEC) && (pc_reg < text_end_reg) && (opc == 6'd0)
                        && (fn == 6'd26 || fn == 6'd27);
    assign sts.div_last = (dcnt_reg == 6'd31);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mem_base_reg <= 32'h0040_0000;
            text_end_reg <= 32'h0050_0000;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                // start address is ignored; reset sets the pc to its fixed default
                CFG_START_PC: ;
                CFG_MEM_BASE: mem_base_reg <= cfg_data;
                CFG_TEXT_END: text_end_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // item capture and operand read
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg <= op;
            ins_reg <= instr;
            ta_reg <= target_addr;
            wd_reg <= write_data;
        end
        if (cmd.read)
        begin
            a_reg <= gpr_a;
            b_reg <= gpr_b;
            inrange_reg <= off_pre < (32'(MemWords) << 2);
            wi_reg <= off_exec[MemAw+1:2];
        end
    end

    // data memory: registered read in read step, write in writeback
    logic        mem_we;
    logic [31:0] mem_wdata;
    assign mem_we = cmd.wb && mw_reg;
    assign mem_wdata = mv_reg;
    always_ff @(posedge clk)
    begin
        if (cmd.read)
            w_reg <= mem[off_exec[MemAw+1:2]];
        if (mem_we)
            mem[wi_reg] <= mem_wdata;
    end

    // execute
    logic [31:0] x_npc, x_val, x_ma, x_mv, x_nhi, x_nlo, x_sd, x_lb, sh_sra;
    logic [2:0]  x_st;
    logic        x_wr, x_mw, x_mem;
    logic [4:0]  x_dst, x_ri;
    logic [3:0]  x_mm;
    logic [1:0]  bo;
    logic [4:0]  bsh;
    logic        misal;
    always_comb
    begin
        x_npc = pc_reg; x_val = 32'd0; x_ma = 32'd0; x_mv = 32'd0;
        x_nhi = hi_reg; x_nlo = lo_reg; x_st = ST_OK; x_wr = 1'b0; x_mw = 1'b0;
        x_mem = 1'b0; x_dst = 5'd0; x_ri = 5'd0; x_mm = 4'd0; x_sd = 32'd0;
        x_lb = 32'd0; sh_sra = 32'd0; misal = 1'b0;
        bo = ea[1:0];
        bsh = {bo, 3'b000};
        case (op_reg)
            OP_LOAD:
            begin
                if (inrange_reg)
                begin
                    x_mw = 1'b1; x_ma = ta_reg; x_mv = wd_reg; x_mm = 4'hF;
                end
                else
                    x_st = ST_RANGE;
            end
            OP_WREG:
            begin
                if (ta_reg > 32'd31)
                    x_st = ST_RANGE;
                else if (ta_reg[4:0] != 5'd0)
                begin
                    x_wr = 1'b1; x_dst = ta_reg[4:0]; x_val = wd_reg;
                end
            end
            OP_RREG:
            begin
                if (ta_reg > 32'd31)
                    x_st = ST_RANGE;
                else
                begin
                    x_ri = ta_reg[4:0];
                    x_val = (ta_reg[4:0] == 5'd0) ? 32'd0 : gpr_reg[ta_reg[4:0]];
                end
            end
            default:
            begin
                if (pc_reg >= text_end_reg)
                    x_st = ST_HALT;
                else
                begin
                    x_npc = pc4;
                    if (opc == 6'd0)
                    begin
                        x_dst = rd; x_wr = 1'b1;
                        case (fn)
                            6'd0: x_val = b_reg << sa;
                            6'd2: x_val = b_reg >> sa;
                            6'd3: x_val = 32'($signed(b_reg) >>> sa);
                            6'd4: x_val = b_reg << a_reg[4:0];
                            6'd6: x_val = b_reg >> a_reg[4:0];
                            6'd7: x_val = 32'($signed(b_reg) >>> a_reg[4:0]);
                            6'd8: begin x_wr = 1'b0; x_npc = a_reg; end
                            6'd9: begin x_npc = a_reg; x_val = pc4; end
                            6'd12: begin x_wr = 1'b0; x_st = ST_SYSCALL; end
                            6'd16: x_val = hi_reg;
                            6'd17: begin x_wr = 1'b0; x_nhi = a_reg; end
                            6'd18: x_val = lo_reg;
                            6'd19: begin x_wr = 1'b0; x_nlo = a_reg; end
                            6'd24, 6'd25, 6'd26, 6'd27: x_wr = 1'b0;
                            6'd32, 6'd33: x_val = a_reg + b_reg;
                            6'd34, 6'd35: x_val = a_reg - b_reg;
                            6'd36: x_val = a_reg & b_reg;
                            6'd37: x_val = a_reg | b_reg;
                            6'd38: x_val = a_reg ^ b_reg;
                            6'd39: x_val = ~(a_reg | b_reg);
                            6'd42: x_val = {31'd0, $signed(a_reg) < $signed(b_reg)};
                            6'd43: x_val = {31'd0, a_reg < b_reg};
                            default: begin x_wr = 1'b0; x_st = ST_INVALID; end
                        endcase
                    end
                    else
                    begin
                        x_dst = rt;
                        case (opc)
                            6'd1:
                            begin
                                if (rt == 5'd0) begin if (a_reg[31]) x_npc = br_tgt; end
                                else if (rt == 5'd1) begin if (!a_reg[31]) x_npc = br_tgt; end
                                else x_st = ST_INVALID;
                            end
                            6'd2: x_npc = {pc4[31:28], ins_reg[25:0], 2'b00};
                            6'd3:
                            begin
                                x_npc = {pc4[31:28], ins_reg[25:0], 2'b00};
                                x_wr = 1'b1; x_dst = 5'd31; x_val = pc4;
                            end
                            6'd4: if (a_reg == b_reg) x_npc = br_tgt;
                            6'd5: if (a_reg != b_reg) x_npc = br_tgt;
                            6'd6:
                            begin
                                if (rt != 5'd0) x_st = ST_INVALID;
                                else if (a_reg[31] || a_reg == 32'd0) x_npc = br_tgt;
                            end
                            6'd7:
                            begin
                                if (rt != 5'd0) x_st = ST_INVALID;
                                else if (!a_reg[31] && a_reg != 32'd0) x_npc = br_tgt;
                            end
                            6'd8, 6'd9: begin x_wr = 1'b1; x_val = a_reg + simm; end
                            6'd10: begin x_wr = 1'b1;
                                x_val = {31'd0, $signed(a_reg) < $signed(simm)}; end
                            6'd11: begin x_wr = 1'b1; x_val = {31'd0, a_reg < simm}; end
                            6'd12: begin x_wr = 1'b1; x_val = a_reg & imm; end
                            6'd13: begin x_wr = 1'b1; x_val = a_reg | imm; end
                            6'd14: begin x_wr = 1'b1; x_val = a_reg ^ imm; end
                            6'd15: begin x_wr = 1'b1; x_val = {ins_reg[15:0], 16'd0}; end
                            6'd32, 6'd33, 6'd34, 6'd35, 6'd36, 6'd37, 6'd38,
                            6'd40, 6'd41, 6'd42, 6'd43, 6'd46: x_mem = 1'b1;
                            default: x_st = ST_INVALID;
                        endcase
                    end
                    if (x_mem)
                    begin
                        misal = ((opc == 6'd33 || opc == 6'd37 || opc == 6'd41) && ea[0])
                              || ((opc == 6'd35 || opc == 6'd43) && bo != 2'd0);
                        if (!inrange_reg || misal)
                            x_st = ST_RANGE;
                        else
                        begin
                            x_ma = ea;
                            case (opc)
                                6'd32: begin x_wr = 1'b1;
                                    x_val = {{24{w_reg[bsh+7]}}, w_reg[bsh +: 8]}; end
                                6'd36: begin x_wr = 1'b1; x_val = {24'd0, w_reg[bsh +: 8]}; end
                                6'd33: begin x_wr = 1'b1;
                                    x_val = {{16{w_reg[bsh+15]}}, w_reg[bsh +: 16]}; end
                                6'd37: begin x_wr = 1'b1; x_val = {16'd0, w_reg[bsh +: 16]}; end
                                6'd35: begin x_wr = 1'b1; x_val = w_reg; end
                                6'd34: begin x_wr = 1'b1;
                                    x_val = (b_reg & (32'h00FF_FFFF >> bsh))
                                          | (w_reg << (5'd24 - bsh)); end
                                6'd38: begin x_wr = 1'b1;
                                    x_val = (bo == 2'd0) ? w_reg
                                          : ((b_reg & ~(32'hFFFF_FFFF >> bsh))
                                             | (w_reg >> bsh)); end
                                6'd40: begin x_mw = 1'b1; x_mm = 4'b0001 << bo;
                                    x_sd = {24'd0, b_reg[7:0]} << bsh; end
                                6'd41: begin x_mw = 1'b1; x_mm = 4'b0011 << bo;
                                    x_sd = {16'd0, b_reg[15:0]} << bsh; end
                                6'd43: begin x_mw = 1'b1; x_mm = 4'hF; x_sd = b_reg; end
                                6'd42: begin x_mw = 1'b1; x_mm = 4'b1111 >> (2'd3 - bo);
                                    x_sd = b_reg >> (5'd24 - bsh); end
                                default: begin x_mw = 1'b1; x_mm = 4'b1111 << bo;
                                    x_sd = b_reg << bsh; end
                            endcase
                            if (x_mw)
                            begin
                                x_lb = lane_bits(x_mm);
                                x_mv = (w_reg & ~x_lb) | (x_sd & x_lb);
                            end
                        end
                    end
                    if (x_st == ST_INVALID || x_st == ST_RANGE)
                    begin
                        x_wr = 1'b0; x_mw = 1'b0; x_ma = 32'd0; x_mv = 32'd0; x_mm = 4'd0;
                        x_npc = pc4; x_nhi = hi_reg; x_nlo = lo_reg;
                    end
                end
            end
        endcase
        if (x_wr && x_dst == 5'd0)
            x_wr = 1'b0;
        if (op_reg != OP_RREG)
            x_ri = x_wr ? x_dst : 5'd0;
        if (op_reg != OP_RREG && !x_wr)
            x_val = 32'd0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            npc_reg <= x_npc; val_reg <= x_val; ma_reg <= x_ma; mv_reg <= x_mv;
            nhi_reg <= x_nhi; nlo_reg <= x_nlo; st_reg <= x_st; wr_reg <= x_wr;
            mw_reg <= x_mw; dst_reg <= x_dst; ri_reg <= x_ri; mm_reg <= x_mm;
        end
    end

    // multiply: one signed 33x33 product, registered
    logic signed [32:0] ma_s, mb_s;
    logic signed [65:0] mprod;
    assign ma_s = {(fn == 6'd24) & a_reg[31], a_reg};
    assign mb_s = {(fn == 6'd24) & b_reg[31], b_reg};
    assign mprod = ma_s * mb_s;

    // divide: restoring, one quotient bit a cycle on magnitudes
    logic [31:0] na, nb, dtry_r;
    logic [32:0] dsub;
    assign na = ((fn == 6'd26) && a_reg[31]) ? 32'd0 - a_reg : a_reg;
    assign nb = ((fn == 6'd26) && b_reg[31]) ? 32'd0 - b_reg : b_reg;
    assign dtry_r = {dr_reg[30:0], dq_reg[31]};
    assign dsub = {dr_reg, dq_reg[31]} - {1'b0, dd_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_pend_reg <= 1'b0;
            div_pend_reg <= 1'b0;
            dcnt_reg <= 6'd0;
        end
        else
        begin
            if (cmd.mul_start) mul_pend_reg <= 1'b1;
            else if (cmd.wb) mul_pend_reg <= 1'b0;
            if (cmd.div_start)
            begin
                div_pend_reg <= 1'b1;
                dcnt_reg <= 6'd0;
            end
            else if (cmd.div_step)
                dcnt_reg <= dcnt_reg + 6'd1;
            else if (cmd.wb)
                div_pend_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul_start)
            prod_reg <= mprod[63:0];
        if (cmd.div_start)
        begin
            dq_reg <= na; dr_reg <= 32'd0; dd_reg <= nb;
            dneg_q_reg <= (fn == 6'd26) && (a_reg[31] ^ b_reg[31]);
            dneg_r_reg <= (fn == 6'd26) && a_reg[31];
            dvalid_reg <= b_reg != 32'd0;
        end
        else if (cmd.div_step)
        begin
            if (!dsub[32])
            begin
                dr_reg <= dsub[31:0];
                dq_reg <= {dq_reg[30:0], 1'b1};
            end
            else
            begin
                dr_reg <= dtry_r;
                dq_reg <= {dq_reg[30:0], 1'b0};
            end
        end
    end

    // writeback of architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hi_reg <= 32'd0;
            lo_reg <= 32'd0;
            pc_reg <= 32'h0040_0000;
            for (int i = 0; i < 32; i++)
                gpr_reg[i] <= 32'd0;
        end
        else
        begin
            if (cmd.wb)
            begin
                pc_reg <= npc_reg;
                if (mul_pend_reg)
                begin
                    hi_reg <= prod_reg[63:32];
                    lo_reg <= prod_reg[31:0];
                end
                else if (div_pend_reg)
                begin
                    if (dvalid_reg)
                    begin
                        lo_reg <= dneg_q_reg ? 32'd0 - dq_reg : dq_reg;
                        hi_reg <= dneg_r_reg ? 32'd0 - dr_reg : dr_reg;
                    end
                end
                else
                begin
                    hi_reg <= nhi_reg;
                    lo_reg <= nlo_reg;
                end
                if (wr_reg)
                    gpr_reg[dst_reg] <= val_reg;
            end
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            next_pc <= pc_reg;
            status <= st_reg;
            reg_written <= wr_reg;
            reg_index <= ri_reg;
            reg_value <= val_reg;
            mem_written <= mw_reg;
            mem_addr <= ma_reg;
            mem_value <= mv_reg;
            mem_byte_mask <= mm_reg;
            hi_value <= hi_reg;
            lo_value <= lo_reg;
        end
    end

    `ASSERT_IMPL(a_r0_zero, clk, rst_n, gpr_reg[0] == 32'd0, "r0 not zero")
    `ASSERT_IMPL(a_one_unit, clk, rst_n, !(mul_pend_reg && div_pend_reg), "mul and div pending")
    `ASSERT_IMPL(a_wr_nonzero, clk, rst_n, !(cmd.wb && wr_reg && dst_reg == 5'd0),
        "write to r0")
endmodule

FILE: verif/testbench.sv
// testbench for the mips-i integer executor: random and directed instruction streams
// checked item by item against a scoreboard that predicts every result field
// depends on miie_pkg and mips_integer_instruction_executor_unit
`timescale 1ns / 100ps

module testbench;
    import miie_pkg::*;

    // primary opcodes
    localparam logic [5:0] OPC_SPECIAL = 6'd0;
    localparam logic [5:0] OPC_REGIMM = 6'd1;
    localparam logic [5:0] OPC_J = 6'd2;
    localparam logic [5:0] OPC_JAL = 6'd3;
    localparam logic [5:0] OPC_BEQ = 6'd4;
    localparam logic [5:0] OPC_BNE = 6'd5;
    localparam logic [5:0] OPC_BLEZ = 6'd6;
    localparam logic [5:0] OPC_BGTZ = 6'd7;
    localparam logic [5:0] OPC_ADDI = 6'd8;
    localparam logic [5:0] OPC_ADDIU = 6'd9;
    localparam logic [5:0] OPC_SLTI = 6'd10;
    localparam logic [5:0] OPC_SLTIU = 6'd11;
    localparam logic [5:0] OPC_ANDI = 6'd12;
    localparam logic [5:0] OPC_ORI = 6'd13;
    localparam logic [5:0] OPC_XORI = 6'd14;
    localparam logic [5:0] OPC_LUI = 6'd15;
    localparam logic [5:0] OPC_LB = 6'd32;
    localparam logic [5:0] OPC_LH = 6'd33;
    localparam logic [5:0] OPC_LWL = 6'd34;
    localparam logic [5:0] OPC_LW = 6'd35;
    localparam logic [5:0] OPC_LBU = 6'd36;
    localparam logic [5:0] OPC_LHU = 6'd37;
    localparam logic [5:0] OPC_LWR = 6'd38;
    localparam logic [5:0] OPC_SB = 6'd40;
    localparam logic [5:0] OPC_SH = 6'd41;
    localparam logic [5:0] OPC_SWL = 6'd42;
    localparam logic [5:0] OPC_SW = 6'd43;
    localparam logic [5:0] OPC_SWR = 6'd46;

    // special function codes
    localparam logic [5:0] FN_SLL = 6'd0;
    localparam logic [5:0] FN_SRL = 6'd2;
    localparam logic [5:0] FN_SRA = 6'd3;
    localparam logic [5:0] FN_SLLV = 6'd4;
    localparam logic [5:0] FN_SRLV = 6'd6;
    localparam logic [5:0] FN_SRAV = 6'd7;
    localparam logic [5:0] FN_JR = 6'd8;
    localparam logic [5:0] FN_JALR = 6'd9;
    localparam logic [5:0] FN_SYSCALL = 6'd12;
    localparam logic [5:0] FN_MFHI = 6'd16;
    localparam logic [5:0] FN_MTHI = 6'd17;
    localparam logic [5:0] FN_MFLO = 6'd18;
    localparam logic [5:0] FN_MTLO = 6'd19;
    localparam logic [5:0] FN_MULT = 6'd24;
    localparam logic [5:0] FN_MULTU = 6'd25;
    localparam logic [5:0] FN_DIV = 6'd26;
    localparam logic [5:0] FN_DIVU = 6'd27;
    localparam logic [5:0] FN_ADD = 6'd32;
    localparam logic [5:0] FN_ADDU = 6'd33;
    localparam logic [5:0] FN_SUB = 6'd34;
    localparam logic [5:0] FN_SUBU = 6'd35;
    localparam logic [5:0] FN_AND = 6'd36;
    localparam logic [5:0] FN_OR = 6'd37;
    localparam logic [5:0] FN_XOR = 6'd38;
    localparam logic [5:0] FN_NOR = 6'd39;
    localparam logic [5:0] FN_SLT = 6'd42;
    localparam logic [5:0] FN_SLTU = 6'd43;

    // regimm rt codes
    localparam logic [4:0] RT_BLTZ = 5'd0;
    localparam logic [4:0] RT_BGEZ = 5'd1;

    localparam logic [31:0] MEM_BYTES = MemWords * 4;
    localparam int CYCLE_LIMIT = 1500000;

    typedef struct packed {
        logic [31:0] npc;
        logic [2:0]  st;
        logic        rw;
        logic [4:0]  ri;
        logic [31:0] rv;
        logic        mw;
        logic [31:0] ma;
        logic [31:0] mv;
        logic [3:0]  mm;
        logic [31:0] hi;
        logic [31:0] lo;
    } exec_result_t;

    // predicts the executor and checks its results in order
    class exec_scoreboard;
        logic [31:0] start_pc = 32'h0040_0000;
        logic [31:0] mem_base = 32'h0040_0000;
        logic [31:0] text_end = 32'h0050_0000;
        logic [31:0] gpr [32];
        logic [31:0] hi, lo, pc;
        logic [31:0] dmem [MemWords];
        bit          written [MemWords];
        int          written_q [$];
        exec_result_t expected_q [$];
        exec_result_t cur;
        int          errors = 0;
        int          checked = 0;

        function new();
            foreach (gpr[i]) gpr[i] = 32'h0;
            hi = 32'h0;
            lo = 32'h0;
            pc = start_pc;
        endfunction

        function void set_cfg(logic [1:0] idx, logic [31:0] v);
            if (idx == CFG_START_PC) start_pc = v;
            else if (idx == CFG_MEM_BASE) mem_base = v;
            else if (idx == CFG_TEXT_END) text_end = v;
        endfunction

        function bit map_word(logic [31:0] a, output int wi);
            logic [31:0] off;
            off = a - mem_base;
            wi = int'(off >> 2);
            return off < MEM_BYTES;
        endfunction

        function void store_word(int wi, logic [31:0] w);
            dmem[wi] = w;
            if (!written[wi]) written_q.push_back(wi);
            written[wi] = 1'b1;
        endfunction

        function void exec_instr(logic [31:0] ins);
            logic [31:0] pc4, a, b, simm, imm, ea, br, npc, val, w, nhi, nlo;
            logic [31:0] sdata, lanes, na, nb, q, m;
            logic [63:0] p;
            logic [5:0]  opc, fn;
            logic [4:0]  rs, rt, rd, sa, dst;
            logic [2:0]  st;
            logic [3:0]  smask;
            int          bo, wi;
            bit          wr, mw, mem;
            pc4 = pc + 32'd4;
            opc = ins[31:26];
            fn = ins[5:0];
            rs = ins[25:21];
            rt = ins[20:16];
            rd = ins[15:11];
            sa = ins[10:6];
            imm = {16'h0, ins[15:0]};
            simm = {{16{ins[15]}}, ins[15:0]};
            a = gpr[rs];
            b = gpr[rt];
            ea = a + simm;
            br = pc4 + (simm << 2);
            npc = pc4;
            st = ST_OK;
            dst = 5'd0;
            val = 32'h0;
            nhi = hi;
            nlo = lo;
            wr = 0;
            mw = 0;
            mem = 0;
            smask = 4'h0;
            sdata = 32'h0;
            if (opc == OPC_SPECIAL) begin
                dst = rd;
                wr = 1;
                case (fn)
                    FN_SLL: val = b << sa;
                    FN_SRL: val = b >> sa;
                    FN_SRA: val = $signed(b) >>> sa;
                    FN_SLLV: val = b << a[4:0];
                    FN_SRLV: val = b >> a[4:0];
                    FN_SRAV: val = $signed(b) >>> a[4:0];
                    FN_JR:
                    begin
                        wr = 0;
                        npc = a;
                    end
                    FN_JALR:
                    begin
                        npc = a;
                        val = pc4;
                    end
                    FN_SYSCALL:
                    begin
                        wr = 0;
                        st = ST_SYSCALL;
                    end
                    FN_MFHI: val = hi;
                    FN_MTHI:
                    begin
                        wr = 0;
                        nhi = a;
                    end
                    FN_MFLO: val = lo;
                    FN_MTLO:
                    begin
                        wr = 0;
                        nlo = a;
                    end
                    FN_MULT, FN_MULTU:
                    begin
                        wr = 0;
                        if (fn == FN_MULT)
                            p = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
                        else
                            p = {32'h0, a} * {32'h0, b};
                        nhi = p[63:32];
                        nlo = p[31:0];
                    end
                    FN_DIV, FN_DIVU:
                    begin
                        wr = 0;
                        // division by zero keeps hi and lo
                        if (b != 0) begin
                            if (fn == FN_DIVU) begin
                                nlo = a / b;
                                nhi = a % b;
                            end
                            else begin
                                na = a[31] ? -a : a;
                                nb = b[31] ? -b : b;
                                q = na / nb;
                                m = na % nb;
                                if (a[31] ^ b[31]) q = -q;
                                if (a[31]) m = -m;
                                nlo = q;
                                nhi = m;
                            end
                        end
                    end
                    FN_ADD, FN_ADDU: val = a + b;
                    FN_SUB, FN_SUBU: val = a - b;
                    FN_AND: val = a & b;
                    FN_OR: val = a | b;
                    FN_XOR: val = a ^ b;
                    FN_NOR: val = ~(a | b);
                    FN_SLT: val = {31'h0, $signed(a) < $signed(b)};
                    FN_SLTU: val = {31'h0, a < b};
                    default: st = ST_INVALID;
                endcase
            end
            else begin
                dst = rt;
                case (opc)
                    OPC_REGIMM:
                        if (rt == RT_BLTZ) begin
                            if (a[31]) npc = br;
                        end
                        else if (rt == RT_BGEZ) begin
                            if (!a[31]) npc = br;
                        end
                        else st = ST_INVALID;
                    OPC_J: npc = {pc4[31:28], ins[25:0], 2'b00};
                    OPC_JAL:
                    begin
                        npc = {pc4[31:28], ins[25:0], 2'b00};
                        wr = 1;
                        dst = 5'd31;
                        val = pc4;
                    end
                    OPC_BEQ: if (a == b) npc = br;
                    OPC_BNE: if (a != b) npc = br;
                    OPC_BLEZ:
                        if (rt != 0) st = ST_INVALID;
                        else if (a[31] || a == 0) npc = br;
                    OPC_BGTZ:
                        if (rt != 0) st = ST_INVALID;
                        else if (!a[31] && a != 0) npc = br;
                    OPC_ADDI, OPC_ADDIU:
                    begin
                        wr = 1;
                        val = a + simm;
                    end
                    OPC_SLTI:
                    begin
                        wr = 1;
                        val = {31'h0, $signed(a) < $signed(simm)};
                    end
                    OPC_SLTIU:
                    begin
                        wr = 1;
                        val = {31'h0, a < simm};
                    end
                    OPC_ANDI:
                    begin
                        wr = 1;
                        val = a & imm;
                    end
                    OPC_ORI:
                    begin
                        wr = 1;
                        val = a | imm;
                    end
                    OPC_XORI:
                    begin
                        wr = 1;
                        val = a ^ imm;
                    end
                    OPC_LUI:
                    begin
                        wr = 1;
                        val = {ins[15:0], 16'h0};
                    end
                    OPC_LB, OPC_LH, OPC_LWL, OPC_LW, OPC_LBU, OPC_LHU, OPC_LWR,
                    OPC_SB, OPC_SH, OPC_SWL, OPC_SW, OPC_SWR: mem = 1;
                    default: st = ST_INVALID;
                endcase
            end

            if (mem) begin
                bo = int'(ea[1:0]);
                if (!map_word(ea, wi) ||
                    ((opc == OPC_LH || opc == OPC_LHU || opc == OPC_SH) && ea[0]) ||
                    ((opc == OPC_LW || opc == OPC_SW) && bo != 0)) begin
                    st = ST_RANGE;
                end
                else begin
                    w = dmem[wi];
                    cur.ma = ea;
                    case (opc)
                        OPC_LB:
                        begin
                            wr = 1;
                            val = w >> (8 * bo);
                            val = {{24{val[7]}}, val[7:0]};
                        end
                        OPC_LBU:
                        begin
                            wr = 1;
                            val = (w >> (8 * bo)) & 32'hFF;
                        end
                        OPC_LH:
                        begin
                            wr = 1;
                            val = w >> (8 * bo);
                            val = {{16{val[15]}}, val[15:0]};
                        end
                        OPC_LHU:
                        begin
                            wr = 1;
                            val = (w >> (8 * bo)) & 32'hFFFF;
                        end
                        OPC_LW:
                        begin
                            wr = 1;
                            val = w;
                        end
                        // unaligned loads merge with the old register
                        OPC_LWL:
                        begin
                            wr = 1;
                            val = (b & (32'h00FF_FFFF >> (8 * bo))) | (w << (24 - 8 * bo));
                        end
                        OPC_LWR:
                        begin
                            wr = 1;
                            val = (b & ~(32'hFFFF_FFFF >> (8 * bo))) | (w >> (8 * bo));
                        end
                        OPC_SB:
                        begin
                            mw = 1;
                            smask = 4'h1 << bo;
                            sdata = (b & 32'hFF) << (8 * bo);
                        end
                        OPC_SH:
                        begin
                            mw = 1;
                            smask = 4'h3 << bo;
                            sdata = (b & 32'hFFFF) << (8 * bo);
                        end
                        OPC_SW:
                        begin
                            mw = 1;
                            smask = 4'hF;
                            sdata = b;
                        end
                        OPC_SWL:
                        begin
                            mw = 1;
                            smask = 4'hF >> (3 - bo);
                            sdata = b >> (24 - 8 * bo);
                        end
                        default:
                        begin
                            mw = 1;
                            smask = 4'hF << bo;
                            sdata = b << (8 * bo);
                        end
                    endcase
                    if (mw) begin
                        for (int i = 0; i < 4; i++)
                            lanes[8*i +: 8] = {8{smask[i]}};
                        w = (w & ~lanes) | (sdata & lanes);
                        store_word(wi, w);
                        cur.mw = 1'b1;
                        cur.mv = w;
                        cur.mm = smask;
                    end
                end
            end

            pc = pc4;
            cur.st = st;
            // faults only advance the pc
            if (st == ST_INVALID || st == ST_RANGE) begin
                cur.ma = 32'h0;
                cur.npc = pc4;
                return;
            end
            hi = nhi;
            lo = nlo;
            if (wr && dst != 0) begin
                gpr[dst] = val;
                cur.rw = 1'b1;
                cur.ri = dst;
                cur.rv = val;
            end
            pc = npc;
            cur.npc = npc;
        endfunction

        function void note_item(logic [1:0] op, logic [31:0] ins, logic [31:0] ta,
                                logic [31:0] wd);
            int wi;
            cur = '0;
            cur.npc = pc;
            case (op)
                OP_EXEC:
                    if (pc >= text_end) cur.st = ST_HALT;
                    else exec_instr(ins);
                OP_LOAD:
                    if (map_word(ta, wi)) begin
                        store_word(wi, wd);
                        cur.mw = 1'b1;
                        cur.ma = ta;
                        cur.mv = wd;
                        cur.mm = 4'hF;
                    end
                    else cur.st = ST_RANGE;
                OP_WREG:
                    if (ta > 31) cur.st = ST_RANGE;
                    else if (ta != 0) begin
                        gpr[ta[4:0]] = wd;
                        cur.rw = 1'b1;
                        cur.ri = ta[4:0];
                        cur.rv = wd;
                    end
                default:
                    if (ta > 31) cur.st = ST_RANGE;
                    else begin
                        cur.ri = ta[4:0];
                        cur.rv = gpr[ta[4:0]];
                    end
            endcase
            cur.hi = hi;
            cur.lo = lo;
            expected_q.push_back(cur);
        endfunction

        task report(string field, logic [31:0] got, logic [31:0] want);
            $display("mismatch at result %0d: %s got %h expected %h",
                     checked, field, got, want);
            errors++;
        endtask

        task check_result(logic [207:0] d);
            exec_result_t e;
            if (expected_q.size() == 0) begin
                $display("result %0d arrived with nothing expected", checked);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            if (d[31:0] !== e.npc) report("next_pc", d[31:0], e.npc);
            if (d[34:32] !== e.st) report("status", d[34:32], e.st);
            if (d[35] !== e.rw) report("reg_written", d[35], e.rw);
            if (d[40:36] !== e.ri) report("reg_index", d[40:36], e.ri);
            if (d[72:41] !== e.rv) report("reg_value", d[72:41], e.rv);
            if (d[73] !== e.mw) report("mem_written", d[73], e.mw);
            if (d[105:74] !== e.ma) report("mem_addr", d[105:74], e.ma);
            if (d[137:106] !== e.mv) report("mem_value", d[137:106], e.mv);
            if (d[141:138] !== e.mm) report("mem_byte_mask", d[141:138], e.mm);
            if (d[173:142] !== e.hi) report("hi_value", d[173:142], e.hi);
            if (d[205:174] !== e.lo) report("lo_value", d[205:174], e.lo);
            checked++;
        endtask
    endclass

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    // op, instr, target_addr, write_data from bit 0 up, zero pad
    logic [103:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    // next_pc, status, reg_written, reg_index, reg_value, mem_written, mem_addr,
    // mem_value, mem_byte_mask, hi_value, lo_value from bit 0 up, zero pad
    logic [207:0] m_axis_tdata;
    logic         cfg_we;
    logic [1:0]   cfg_index;
    logic [31:0]  cfg_data;

    exec_scoreboard sb;
    int  cycles = 0;
    int  hold_off = 0;     // long receiver stall, counted down by the sink process
    bit  quiet = 0;        // no idling on either side

    logic [5:0] funct_pool [27] = '{FN_SLL, FN_SRL, FN_SRA, FN_SLLV, FN_SRLV, FN_SRAV,
        FN_JR, FN_JALR, FN_SYSCALL, FN_MFHI, FN_MTHI, FN_MFLO, FN_MTLO, FN_MULT,
        FN_MULTU, FN_DIV, FN_DIVU, FN_ADD, FN_ADDU, FN_SUB, FN_SUBU, FN_AND, FN_OR,
        FN_XOR, FN_NOR, FN_SLT, FN_SLTU};
    logic [5:0] opc_pool [27] = '{OPC_REGIMM, OPC_J, OPC_JAL, OPC_BEQ, OPC_BNE,
        OPC_BLEZ, OPC_BGTZ, OPC_ADDI, OPC_ADDIU, OPC_SLTI, OPC_SLTIU, OPC_ANDI,
        OPC_ORI, OPC_XORI, OPC_LUI, OPC_LB, OPC_LH, OPC_LWL, OPC_LW, OPC_LBU,
        OPC_LHU, OPC_LWR, OPC_SB, OPC_SH, OPC_SWL, OPC_SW, OPC_SWR};

    mips_integer_instruction_executor_unit dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial clk = 1'b0;
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // hard stop in case the handshake hangs
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // result side: ready pattern changes at the falling edge
    initial
    begin
        int stall;
        stall = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_off > 0) begin
                hold_off--;
                m_axis_tready <= 1'b0;
            end
            else if (quiet)
                m_axis_tready <= 1'b1;
            else if (stall > 0) begin
                stall--;
                m_axis_tready <= 1'b0;
            end
            else if ($urandom_range(0, 9) == 0) begin
                // start a ready-low burst whose length is drawn at random, this one included
                stall = $urandom_range(0, 18);
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // results are sampled at the rising edge
    initial
    begin
        forever begin
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata);
        end
    end

    // offer one item and predict it once accepted
    task automatic send_item(logic [1:0] op, logic [31:0] ins, logic [31:0] ta,
                             logic [31:0] wd);
        int gap;
        if (!quiet && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 19);
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {6'h0, wd, ta, ins, op};
        do @(posedge clk); while (!s_axis_tready);
        sb.note_item(op, ins, ta, wd);
    endtask

    // stop offering and let every expected result come back
    task automatic drain();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge clk);
    endtask

    // only called with the block idle
    task automatic write_cfg(logic [1:0] idx, logic [31:0] v);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        @(negedge clk);
        cfg_we <= 1'b0;
        sb.set_cfg(idx, v);
    endtask

    task automatic reconfigure(logic [31:0] spc, logic [31:0] base, logic [31:0] tend);
        drain();
        repeat (10) @(posedge clk);
        write_cfg(CFG_START_PC, spc);
        write_cfg(CFG_MEM_BASE, base);
        write_cfg(CFG_TEXT_END, tend);
    endtask

    function automatic logic [31:0] rtype(logic [5:0] fn, logic [4:0] rs, logic [4:0] rt,
                                          logic [4:0] rd, logic [4:0] sa);
        return {OPC_SPECIAL, rs, rt, rd, sa, fn};
    endfunction

    function automatic logic [31:0] itype(logic [5:0] opc, logic [4:0] rs, logic [4:0] rt,
                                          logic [15:0] imm);
        return {opc, rs, rt, imm};
    endfunction

    function automatic bit is_mem_op(logic [5:0] opc);
        return opc inside {OPC_LB, OPC_LH, OPC_LWL, OPC_LW, OPC_LBU, OPC_LHU, OPC_LWR,
                           OPC_SB, OPC_SH, OPC_SWL, OPC_SW, OPC_SWR};
    endfunction

    // one random instruction; loads and stores mostly get a base register set
    // up first so that they land on a word that holds data
    task automatic exec_random();
        logic [31:0] ins, simm, ea, off, tgt;
        logic [4:0]  rs;
        logic [1:0]  low;
        int          wi;
        bit          unwritten;
        if ($urandom_range(0, 19) == 0)
            ins = $urandom();
        else if ($urandom_range(0, 1) == 0)
            ins = rtype(funct_pool[$urandom_range(0, 26)], 5'($urandom()), 5'($urandom()),
                        5'($urandom()), 5'($urandom()));
        else
            ins = itype(opc_pool[$urandom_range(0, 26)], 5'($urandom()), 5'($urandom()),
                        16'($urandom()));
        if (is_mem_op(ins[31:26]) && sb.pc < sb.text_end) begin
            rs = ins[25:21];
            simm = {{16{ins[15]}}, ins[15:0]};
            ea = sb.gpr[rs] + simm;
            off = ea - sb.mem_base;
            unwritten = off < MEM_BYTES && !sb.written[off >> 2];
            if (unwritten || $urandom_range(0, 9) < 7) begin
                if (rs == 0) rs = 5'($urandom_range(1, 31));
                ins[25:21] = rs;
                wi = sb.written_q[$urandom_range(0, sb.written_q.size() - 1)];
                low = 2'($urandom());
                if ($urandom_range(0, 3) != 0) begin
                    if (ins[31:26] inside {OPC_LW, OPC_SW}) low = 2'b00;
                    if (ins[31:26] inside {OPC_LH, OPC_LHU, OPC_SH}) low[0] = 1'b0;
                end
                tgt = sb.mem_base + 32'(wi) * 4 + {30'h0, low};
                send_item(OP_WREG, $urandom(), {27'h0, rs}, tgt - simm);
            end
        end
        send_item(OP_EXEC, ins, $urandom(), $urandom());
    endtask

    task automatic random_item();
        int pick;
        logic [31:0] ta;
        pick = $urandom_range(0, 99);
        if (pick < 75)
            exec_random();
        else if (pick < 83) begin
            if ($urandom_range(0, 9) < 6)
                ta = sb.mem_base + 32'($urandom_range(0, MemWords - 1)) * 4
                     + $urandom_range(0, 3);
            else
                ta = $urandom();
            send_item(OP_LOAD, $urandom(), ta, $urandom());
        end
        else begin
            ta = ($urandom_range(0, 7) == 0) ? $urandom() : $urandom_range(0, 31);
            send_item(pick < 92 ? OP_WREG : OP_RREG, $urandom(), ta, $urandom());
        end
    endtask

    task automatic random_phase(int count);
        for (int i = 0; i < count; i++) random_item();
    endtask

    initial
    begin
        sb = new();
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        cfg_we = 1'b0;
        cfg_index = CFG_START_PC;
        cfg_data = 32'h0;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        // data for loads: low and high ends of memory
        for (int w = 0; w < 32; w++)
            send_item(OP_LOAD, 32'h0, sb.mem_base + 32'(w) * 4, $urandom());
        for (int w = MemWords - 8; w < MemWords; w++)
            send_item(OP_LOAD, 32'h0, sb.mem_base + 32'(w) * 4 + 3, $urandom());

        // directed part
        send_item(OP_WREG, 32'h0, 32'd1, 32'h8000_0000);
        send_item(OP_WREG, 32'h0, 32'd2, 32'hFFFF_FFFF);
        send_item(OP_WREG, 32'h0, 32'd3, 32'h7FFF_FFFF);
        // write to r0 is dropped, huge index is out of range
        send_item(OP_WREG, 32'h0, 32'd0, 32'hFFFF_FFFF);
        send_item(OP_WREG, 32'h0, 32'hFFFF_FFFF, 32'h1234_5678);
        send_item(OP_RREG, 32'h0, 32'd0, 32'h0);
        send_item(OP_RREG, 32'h0, 32'd32, 32'h0);
        // add wraps
        send_item(OP_EXEC, rtype(FN_ADD, 5'd3, 5'd2, 5'd4, 5'd0), 32'h0, 32'h0);
        // most negative over minus one, then divide by zero
        send_item(OP_EXEC, rtype(FN_DIV, 5'd1, 5'd2, 5'd0, 5'd0), 32'h0, 32'h0);
        send_item(OP_EXEC, rtype(FN_DIVU, 5'd1, 5'd0, 5'd0, 5'd0), 32'h0, 32'h0);
        send_item(OP_EXEC, rtype(FN_MULT, 5'd1, 5'd2, 5'd0, 5'd0), 32'h0, 32'h0);
        send_item(OP_EXEC, rtype(FN_MULTU, 5'd2, 5'd2, 5'd0, 5'd0), 32'h0, 32'h0);
        send_item(OP_EXEC, rtype(FN_MFHI, 5'd0, 5'd0, 5'd5, 5'd0), 32'h0, 32'h0);
        send_item(OP_EXEC, rtype(FN_SRA, 5'd0, 5'd1, 5'd6, 5'd31), 32'h0, 32'h0);
        send_item(OP_EXEC, rtype(FN_SYSCALL, 5'd0, 5'd0, 5'd0, 5'd0), 32'h0, 32'h0);
        // invalid funct, regimm rt and blez rt
        send_item(OP_EXEC, rtype(6'd1, 5'd0, 5'd0, 5'd0, 5'd0), 32'h0, 32'h0);
        send_item(OP_EXEC, itype(OPC_REGIMM, 5'd1, 5'd2, 16'h0004), 32'h0, 32'h0);
        send_item(OP_EXEC, itype(OPC_BLEZ, 5'd0, 5'd1, 16'h0004), 32'h0, 32'h0);
        send_item(OP_LOAD, 32'h0, 32'h0, 32'hDEAD_BEEF);
        // unaligned word merges around an odd address
        send_item(OP_WREG, 32'h0, 32'd7, sb.mem_base + 32'd5);
        send_item(OP_EXEC, itype(OPC_LWL, 5'd7, 5'd8, 16'h0000), 32'h0, 32'h0);
        send_item(OP_EXEC, itype(OPC_SWR, 5'd7, 5'd3, 16'hFFFE), 32'h0, 32'h0);
        send_item(OP_EXEC, itype(OPC_LH, 5'd7, 5'd9, 16'h0000), 32'h0, 32'h0);
        send_item(OP_EXEC, itype(OPC_REGIMM, 5'd0, RT_BGEZ, 16'h0010), 32'h0, 32'h0);
        // jump far past the end of text, then the core is halted
        send_item(OP_EXEC, rtype(FN_JALR, 5'd3, 5'd0, 5'd10, 5'd0), 32'h0, 32'h0);
        send_item(OP_EXEC, rtype(FN_ADDU, 5'd1, 5'd1, 5'd11, 5'd0), 32'h0, 32'h0);

        reconfigure(32'h0, 32'h0, 32'hFFFF_FFFF);
        random_phase(330);

        // memory window wraps past the top of the address space
        reconfigure(32'hFFFF_FFFF, 32'hFFFF_FF00, 32'hFFFF_FFFF);
        random_phase(50);
        // long receiver stall while items keep coming
        hold_off = 400;
        random_phase(280);

        reconfigure(32'h8000_0000, 32'h1000_0000, 32'h7FFF_FFFF);
        random_phase(100);
        drain();
        random_phase(230);

        // every instruction executes as halted
        reconfigure(32'h0040_0000, 32'h0040_0000, 32'h0);
        random_phase(60);

        reconfigure(32'h0040_0000, 32'h0040_0000, 32'hFFFF_FFFF);
        random_phase(180);
        quiet = 1'b1;
        random_phase(150);

        drain();
        repeat (60) @(posedge clk);
        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/miie_pkg.sv
rtl/core/miie_ctrl.sv
rtl/core/miie_dpath.sv
rtl/core/mips_integer_instruction_executor_unit.sv
verif/testbench.sv
